@@ rtl/periodic_timer_bank_unit_assert.svh @@
// ----------------------------------------------------------------------------
// periodic timer bank assertion macros
// shared property forms used by the port checker
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TIMER_BANK_UNIT_ASSERT_SVH
`define PERIODIC_TIMER_BANK_UNIT_ASSERT_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define PTB_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on the rising clock, off during reset
`define PTB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/ptb_pkg.sv @@
// ----------------------------------------------------------------------------
// ptb_pkg
// shared constants and types of the periodic timer bank
// ----------------------------------------------------------------------------
`default_nettype none

package ptb_pkg;

  localparam int NUM_TIMERS_DEF  = 8;
  localparam int COUNT_WIDTH_DEF = 16;

  localparam int KIND_W   = 3;
  localparam int INDEX_W  = 3;
  localparam int PERIOD_W = 16;
  localparam int MASK_W   = 8;

  // operation codes
  localparam logic [KIND_W-1:0] KIND_TICK       = 3'd0;
  localparam logic [KIND_W-1:0] KIND_CREATE     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SET_PERIOD = 3'd2;
  localparam logic [KIND_W-1:0] KIND_RESTART    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_STOP       = 3'd4;
  localparam logic [KIND_W-1:0] KIND_COLLECT    = 3'd5;

  // controller to datapath commands
  typedef struct packed {
    logic load;      // capture the operation fields
    logic rd_sweep;  // read entry at the sweep address for a tick
    logic rd_op;     // read the addressed entry for a restart
    logic apply;     // apply create, set period or stop
    logic report;    // register the masks, clear ready on collect
  } ptb_cmd_t;

endpackage

`default_nettype wire

@@ rtl/ptb_ctrl.sv @@
// ----------------------------------------------------------------------------
// ptb_ctrl
// sequencer of the timer bank: accepts items and steps the datapath
// ----------------------------------------------------------------------------
`default_nettype none

module ptb_ctrl #(
  parameter int NUM_TIMERS = ptb_pkg::NUM_TIMERS_DEF,
  parameter int IDX_W      = 1
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [ptb_pkg::KIND_W-1:0]  kind,
  output logic                             busy,
  output logic                             done,
  output ptb_pkg::ptb_cmd_t                cmd,
  output logic [IDX_W-1:0]                 sweep_addr
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_TICK    = 3'd1;
  localparam logic [2:0] S_RESTART = 3'd2;
  localparam logic [2:0] S_APPLY   = 3'd3;
  localparam logic [2:0] S_FLUSH   = 3'd4;
  localparam logic [2:0] S_REPORT  = 3'd5;

  localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(NUM_TIMERS - 1);

  logic [2:0]       state;
  logic [2:0]       state_next;
  logic [IDX_W-1:0] sweep_addr_next;
  logic             done_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next      = state;
    sweep_addr_next = sweep_addr;
    done_next       = 1'b0;
    cmd             = '0;
    case (state)
      S_IDLE: begin
        sweep_addr_next = '0;
        if (start) begin
          cmd.load = 1'b1;
          if (kind == ptb_pkg::KIND_TICK) begin
            state_next = S_TICK;
          end else if (kind == ptb_pkg::KIND_RESTART) begin
            state_next = S_RESTART;
          end else begin
            state_next = S_APPLY;
          end
        end
      end
      S_TICK: begin
        cmd.rd_sweep = 1'b1;
        if (sweep_addr == LAST_ADDR) begin
          state_next = S_FLUSH;
        end else begin
          sweep_addr_next = sweep_addr + 1'b1;
        end
      end
      S_RESTART: begin
        cmd.rd_op  = 1'b1;
        state_next = S_FLUSH;
      end
      S_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = S_REPORT;
      end
      S_FLUSH: begin
        state_next = S_REPORT;
      end
      S_REPORT: begin
        cmd.report = 1'b1;
        done_next  = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      sweep_addr <= '0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      sweep_addr <= sweep_addr_next;
      done       <= done_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/ptb_datapath.sv @@
// ----------------------------------------------------------------------------
// ptb_datapath
// timer storage, per-entry update unit and result registers
// ----------------------------------------------------------------------------
`default_nettype none

module ptb_datapath #(
  parameter int NUM_TIMERS  = ptb_pkg::NUM_TIMERS_DEF,
  parameter int COUNT_WIDTH = ptb_pkg::COUNT_WIDTH_DEF,
  parameter int IDX_W       = 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire ptb_pkg::ptb_cmd_t             cmd,
  input  wire logic [IDX_W-1:0]              sweep_addr,
  input  wire logic [ptb_pkg::KIND_W-1:0]    kind,
  input  wire logic [ptb_pkg::INDEX_W-1:0]   timer_index,
  input  wire logic [ptb_pkg::PERIOD_W-1:0]  period_value,
  output logic [ptb_pkg::MASK_W-1:0]         running_mask,
  output logic [ptb_pkg::MASK_W-1:0]         ready_mask
);

  // captured operation
  logic [ptb_pkg::KIND_W-1:0] op_kind;
  logic [IDX_W-1:0]           op_addr;
  logic                       op_hit;
  logic [COUNT_WIDTH-1:0]     op_period;

  logic [IDX_W+ptb_pkg::INDEX_W-1:0]        idx_ext;
  logic [COUNT_WIDTH+ptb_pkg::PERIOD_W-1:0] per_ext;

  // per-timer flags; running means the tick sweep counts it down, per_ok means period written
  logic [NUM_TIMERS-1:0] running;
  logic [NUM_TIMERS-1:0] ready;
  logic [NUM_TIMERS-1:0] per_ok;

  // count and period stores
  logic [COUNT_WIDTH-1:0] count_mem  [NUM_TIMERS];
  logic [COUNT_WIDTH-1:0] period_mem [NUM_TIMERS];

  // read stage
  logic [IDX_W-1:0]       rd_addr;
  logic [COUNT_WIDTH-1:0] rd_count;
  logic [COUNT_WIDTH-1:0] rd_period;
  logic [IDX_W-1:0]       pr_addr;
  logic                   pr_tick;
  logic                   pend;

  // update stage
  logic [COUNT_WIDTH-1:0] dec;
  logic [COUNT_WIDTH-1:0] per_eff;
  logic [COUNT_WIDTH-1:0] new_count;
  logic                   fire;

  assign idx_ext = {{IDX_W{1'b0}}, timer_index};
  assign per_ext = {{COUNT_WIDTH{1'b0}}, period_value};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_kind   <= kind;
      op_addr   <= idx_ext[IDX_W-1:0];
      op_hit    <= (32'(timer_index) < NUM_TIMERS);
      op_period <= per_ext[COUNT_WIDTH-1:0];
    end
  end

  assign rd_addr = cmd.rd_op ? op_addr : sweep_addr;

  always_ff @(posedge clk) begin
    rd_count  <= count_mem[rd_addr];
    rd_period <= period_mem[rd_addr];
    pr_addr   <= rd_addr;
    pr_tick   <= cmd.rd_sweep;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= (cmd.rd_sweep & running[rd_addr]) | (cmd.rd_op & op_hit);
    end
  end

  // a timer with an unwritten period reloads as zero
  assign per_eff = per_ok[pr_addr] ? rd_period : '0;
  assign dec     = rd_count - 1'b1;
  assign fire    = pr_tick && (dec == '0);

  always_comb begin
    if (!pr_tick || fire) begin
      new_count = per_eff;
    end else begin
      new_count = dec;
    end
  end

  always_ff @(posedge clk) begin
    if (pend) begin
      count_mem[pr_addr] <= new_count;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply && op_hit &&
        (op_kind == ptb_pkg::KIND_CREATE || op_kind == ptb_pkg::KIND_SET_PERIOD)) begin
      period_mem[op_addr] <= op_period;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= '0;
      ready   <= '0;
      per_ok  <= '0;
    end else begin
      if (pend) begin
        running[pr_addr] <= (new_count != '0);
        if (fire) begin
          ready[pr_addr] <= 1'b1;
        end
      end
      if (cmd.apply && op_hit) begin
        case (op_kind)
          ptb_pkg::KIND_CREATE: begin
            running[op_addr] <= 1'b0;
            ready[op_addr]   <= 1'b0;
            per_ok[op_addr]  <= 1'b1;
          end
          ptb_pkg::KIND_SET_PERIOD: begin
            per_ok[op_addr] <= 1'b1;
          end
          ptb_pkg::KIND_STOP: begin
            running[op_addr] <= 1'b0;
          end
          default: begin
          end
        endcase
      end
      if (cmd.report && op_kind == ptb_pkg::KIND_COLLECT) begin
        ready <= '0;
      end
    end
  end

  // only timers 0 to 7 show in the masks
  logic [ptb_pkg::MASK_W-1:0] run_view;
  logic [ptb_pkg::MASK_W-1:0] rdy_view;

  for (genvar g = 0; g < ptb_pkg::MASK_W; g++) begin : g_mask
    if (g < NUM_TIMERS) begin : g_on
      assign run_view[g] = running[g];
      assign rdy_view[g] = ready[g];
    end else begin : g_off
      assign run_view[g] = 1'b0;
      assign rdy_view[g] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.report) begin
      running_mask <= run_view;
      ready_mask   <= rdy_view;
    end
  end

endmodule

`default_nettype wire

@@ rtl/periodic_timer_bank_unit.sv @@
// ----------------------------------------------------------------------------
// periodic_timer_bank_unit
// bank of periodic countdown timers driven by one operation per item
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Each item produces one
// result: done is high for exactly one cycle with running_mask and ready_mask
// valid in that cycle, and the receiver cannot stall it. A tick keeps busy
// high while the update unit visits every timer, one per cycle, through the
// single read port of the count and period stores, then while it finishes the
// last entry and registers the masks. A restart passes through a store read,
// a count write and a report, every other kind through an apply and a report.
// The result appears in the cycle after busy falls, and the next item may be
// taken in that same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_timer_bank_unit #(
  parameter int NUM_TIMERS  = ptb_pkg::NUM_TIMERS_DEF,
  parameter int COUNT_WIDTH = ptb_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // item side
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [ptb_pkg::KIND_W-1:0]    kind,
  input  wire logic [ptb_pkg::INDEX_W-1:0]   timer_index,
  input  wire logic [ptb_pkg::PERIOD_W-1:0]  period_value,
  // result side
  output logic                               done,
  output logic [ptb_pkg::MASK_W-1:0]         running_mask,
  output logic [ptb_pkg::MASK_W-1:0]         ready_mask
);

  // address width of the timer stores, at least one bit
  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  ptb_pkg::ptb_cmd_t cmd;         // sequencer commands to the datapath
  logic [IDX_W-1:0]  sweep_addr;  // timer visited during a tick

  // sequencer: idle, tick sweep, restart read, apply, flush, report
  ptb_ctrl #(
    .NUM_TIMERS (NUM_TIMERS),
    .IDX_W      (IDX_W)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .kind       (kind),
    .busy       (busy),
    .done       (done),
    .cmd        (cmd),
    .sweep_addr (sweep_addr)
  );

  // stores, update unit and mask registers
  ptb_datapath #(
    .NUM_TIMERS  (NUM_TIMERS),
    .COUNT_WIDTH (COUNT_WIDTH),
    .IDX_W       (IDX_W)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sweep_addr   (sweep_addr),
    .kind         (kind),
    .timer_index  (timer_index),
    .period_value (period_value),
    .running_mask (running_mask),
    .ready_mask   (ready_mask)
  );

endmodule

`default_nettype wire

@@ rtl/ptb_checker.sv @@
// ----------------------------------------------------------------------------
// ptb_checker
// port-level checks of the timer bank handshake and item latency
// ----------------------------------------------------------------------------
`default_nettype none

`include "periodic_timer_bank_unit_assert.svh"

module ptb_checker #(
  parameter int NUM_TIMERS = ptb_pkg::NUM_TIMERS_DEF
) (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        start,
  input wire logic                        busy,
  input wire logic                        done,
  input wire logic [ptb_pkg::KIND_W-1:0]  kind
);

  logic take;
  logic take_tick;
  logic take_short;

  assign take       = start && !busy;
  assign take_tick  = take && (kind == ptb_pkg::KIND_TICK);
  assign take_short = take && (kind != ptb_pkg::KIND_TICK) &&
                      (kind != ptb_pkg::KIND_RESTART);

  `PTB_ASSERT_NEXT(a_take_busy, clk, rst, take, busy, "busy not raised after an item")
  `PTB_ASSERT_IMPL(a_done_idle, clk, rst, done, !busy, "result shown while busy")
  `PTB_ASSERT_NEXT(a_done_pulse, clk, rst, done, !done, "result strobe longer than a cycle")
  `PTB_ASSERT_IMPL(a_short_lat, clk, rst, take_short, ##3 done, "short item result late")
  `PTB_ASSERT_IMPL(a_tick_lat, clk, rst, take_tick, ##(NUM_TIMERS + 3) done, "tick result late")

endmodule

bind periodic_timer_bank_unit ptb_checker #(
  .NUM_TIMERS (NUM_TIMERS)
) u_ptb_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .kind  (kind)
);

`default_nettype wire
